[hdl/linear_srgb_to_oklab_unit_macros.svh]
// Assertion macros for the linear sRGB to Oklab unit checker.
// Depends on a clock and a reset signal named clock and reset in the using scope.
`ifndef LINEAR_SRGB_TO_OKLAB_UNIT_MACROS_SVH
`define LINEAR_SRGB_TO_OKLAB_UNIT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define LSO_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, ignored while reset is high
`define LSO_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that is also checked during reset
`define LSO_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/lso_pkg.sv]
// Shared constants for the linear sRGB to Oklab unit: sample format and matrices.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lso_pkg;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = SAMPLE_BITS - 3;
   localparam int COEF_BITS   = 20;
   localparam int ROOT_STEPS  = 21;
   localparam int CHANNELS    = 3;

   typedef logic signed [23:0] coef_type;

   // Q.20 coefficients, row-major
   localparam coef_type RGB_TO_LMS [9] = '{
      24'sd432246, 24'sd562385, 24'sd53945,
      24'sd222197, 24'sd713765, 24'sd112614,
      24'sd92592,  24'sd295404, 24'sd660581
   };

   localparam coef_type LMSP_TO_LAB [9] = '{
      24'sd220677,  24'sd832169,   -24'sd4270,
      24'sd2074082, -24'sd2546563, 24'sd472482,
      24'sd27162,   24'sd820796,   -24'sd847958
   };
endpackage
`default_nettype wire

[hdl/linear_srgb_to_oklab_unit.sv]
// Linear sRGB to Oklab pixel converter, fully pipelined.
// Throughput one pixel per cycle while the result is not stalled, as one
// cube-root bit is resolved per stage over 21 stages.
// A stalled result holds every stage, bubbles included.
// Reset (synchronous) clears all valid bits; data registers are not reset.
// Depends on lso_pkg.
`timescale 1ns / 1ps
`default_nettype none
module linear_srgb_to_oklab_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // req_tdata: in_red, in_green, in_blue (lowest bits first)
   input  wire logic [3*lso_pkg::SAMPLE_BITS-1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // rsp_tdata: out_lightness, out_green_red, out_blue_yellow (lowest bits first)
   output logic [3*lso_pkg::SAMPLE_BITS-1:0]      rsp_tdata
);
   import lso_pkg::*;

   localparam int MP_W    = 24 + SAMPLE_BITS;
   localparam int LMS_W   = SAMPLE_BITS + 7;
   localparam int ARG_W   = LMS_W + 2 * COEF_BITS;
   localparam int R_W     = 48;
   localparam int Y_W     = ROOT_STEPS;
   localparam int LP_W    = 24 + Y_W + 1;
   localparam int LS_W    = LP_W + 2;
   localparam int SHIFT   = 2 * COEF_BITS - FRAC_BITS;
   localparam logic signed [LS_W-1:0] HALF  = LS_W'(1) <<< (SHIFT - 1);
   localparam logic signed [LS_W-1:0] S_MAX = LS_W'((2 ** (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [LS_W-1:0] S_MIN = -S_MAX - LS_W'(1);

   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // stage 1: matrix products
   logic                    mp_v_ff;
   logic signed [MP_W-1:0]  mp_ff [9];
   logic signed [MP_W-1:0]  mp_in [9];

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         mp_in[i] = MP_W'(RGB_TO_LMS[i]) *
            MP_W'($signed(req_tdata[(i % 3) * SAMPLE_BITS +: SAMPLE_BITS]));
      end
   end

   // stage 2: sum, clamp negatives to zero, round to Q.20; seeds the root pipeline
   logic              rt_v_ff [ROOT_STEPS+1];
   logic [LMS_W-1:0]  rt_a_ff [ROOT_STEPS+1][CHANNELS];
   logic [Y_W-1:0]    rt_y_ff [ROOT_STEPS+1][CHANNELS];
   logic [R_W-1:0]    rt_q_ff [ROOT_STEPS+1][CHANNELS];
   logic [R_W-1:0]    rt_r_ff [ROOT_STEPS+1][CHANNELS];
   logic [LMS_W-1:0]  lms_in  [CHANNELS];

   always_comb begin
      logic signed [MP_W+1:0] s;
      for (int l = 0; l < CHANNELS; l++) begin
         s = (MP_W+2)'(mp_ff[3*l]) + (MP_W+2)'(mp_ff[3*l+1]) + (MP_W+2)'(mp_ff[3*l+2]);
         if (s <= 0) begin
            lms_in[l] = '0;
         end else begin
            lms_in[l] = LMS_W'((s + ((MP_W+2)'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mp_v_ff    <= 1'b0;
         rt_v_ff[0] <= 1'b0;
      end else if (advance) begin
         mp_v_ff    <= req_tvalid;
         rt_v_ff[0] <= mp_v_ff;
      end
      if (advance) begin
         mp_ff <= mp_in;
         for (int l = 0; l < CHANNELS; l++) begin
            rt_a_ff[0][l] <= lms_in[l];
            rt_y_ff[0][l] <= '0;
            rt_q_ff[0][l] <= '0;
            rt_r_ff[0][l] <= '0;
         end
      end
   end

   // root stages: one result bit each, from three argument bits
   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
      localparam int GRP = ROOT_STEPS - 1 - k;
      logic [Y_W-1:0] y_in [CHANNELS];
      logic [R_W-1:0] q_in [CHANNELS];
      logic [R_W-1:0] r_in [CHANNELS];

      always_comb begin
         logic [ARG_W-1:0] arg;
         logic [R_W-1:0]   ys, rs, sqs, d;
         for (int l = 0; l < CHANNELS; l++) begin
            arg = {rt_a_ff[k][l], {(2*COEF_BITS){1'b0}}};
            ys  = R_W'(rt_y_ff[k][l]) << 1;
            rs  = (rt_r_ff[k][l] << 3) | R_W'(arg[3*GRP +: 3]);
            sqs = rt_q_ff[k][l] << 2;
            d   = (sqs << 1) + sqs + (ys << 1) + ys + R_W'(1);
            if (rs >= d) begin
               y_in[l] = Y_W'(ys + R_W'(1));
               q_in[l] = sqs + (ys << 1) + R_W'(1);
               r_in[l] = rs - d;
            end else begin
               y_in[l] = Y_W'(ys);
               q_in[l] = sqs;
               r_in[l] = rs;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rt_v_ff[k+1] <= 1'b0;
         end else if (advance) begin
            rt_v_ff[k+1] <= rt_v_ff[k];
         end
         if (advance) begin
            for (int l = 0; l < CHANNELS; l++) begin
               rt_a_ff[k+1][l] <= rt_a_ff[k][l];
               rt_y_ff[k+1][l] <= y_in[l];
               rt_q_ff[k+1][l] <= q_in[l];
               rt_r_ff[k+1][l] <= r_in[l];
            end
         end
      end
   end

   // Lab products, then sum, round and saturate into the output register
   logic                   lp_v_ff;
   logic signed [LP_W-1:0] lp_ff [9];
   logic signed [LP_W-1:0] lp_in [9];
   logic [3*SAMPLE_BITS-1:0] out_in;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         lp_in[i] = LP_W'(LMSP_TO_LAB[i]) *
            LP_W'($signed({1'b0, rt_y_ff[ROOT_STEPS][i % 3]}));
      end
   end

   always_comb begin
      logic signed [LS_W-1:0] s, q;
      for (int l = 0; l < CHANNELS; l++) begin
         s = LS_W'(lp_ff[3*l]) + LS_W'(lp_ff[3*l+1]) + LS_W'(lp_ff[3*l+2]);
         q = (s + HALF) >>> SHIFT;
         if (q > S_MAX) begin
            q = S_MAX;
         end else if (q < S_MIN) begin
            q = S_MIN;
         end
         out_in[l*SAMPLE_BITS +: SAMPLE_BITS] = q[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_v_ff    <= 1'b0;
         rsp_tvalid <= 1'b0;
      end else if (advance) begin
         lp_v_ff    <= rt_v_ff[ROOT_STEPS];
         rsp_tvalid <= lp_v_ff;
      end
      if (advance) begin
         lp_ff     <= lp_in;
         rsp_tdata <= out_in;
      end
   end
endmodule
`default_nettype wire

[hdl/lso_checker.sv]
// Port-level checker for the linear sRGB to Oklab unit, bound to the top level.
// Depends on lso_pkg and linear_srgb_to_oklab_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "linear_srgb_to_oklab_unit_macros.svh"
module lso_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [3*lso_pkg::SAMPLE_BITS-1:0] req_tdata,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [3*lso_pkg::SAMPLE_BITS-1:0] rsp_tdata
);
   import lso_pkg::*;

   logic [3*SAMPLE_BITS-1:0] req_seen;
   assign req_seen = req_tdata;

   // the pipeline advances exactly when the output slot is free or drained
   `LSO_ASSERT_NOW(a_ready_follows_output, req_seen == req_seen,
      req_tready == (!rsp_tvalid || rsp_tready), "req_tready does not track output stall")
   `LSO_ASSERT_ALWAYS(a_reset_clears, reset, !rsp_tvalid, "result valid after reset")
   `LSO_ASSERT_NEXT(a_rsp_holds, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped")
   `LSO_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata),
      "stalled result changed")
   // a stalled pipeline takes no request
   `LSO_ASSERT_NOW(a_no_take_on_stall, rsp_tvalid && !rsp_tready && req_tvalid, !req_tready,
      "request taken while result stalled")
endmodule

bind linear_srgb_to_oklab_unit lso_checker u_lso_checker (.*);
`default_nettype wire
